FILE: rtl/gbhp_pkg.sv
// Shared types and constants for the geometry blob header parser.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package gbhp_pkg;

  // Header magic and version bytes
  localparam logic [7:0] MAGIC_0      = 8'h47;
  localparam logic [7:0] MAGIC_1      = 8'h50;
  localparam logic [7:0] VERSION_BYTE = 8'h00;

  // Flag bit positions and envelope code field
  localparam int FLAG_LE_BIT    = 0;
  localparam int FLAG_EMPTY_BIT = 4;
  localparam int FLAG_EXT_BIT   = 5;
  localparam logic [2:0] ENV_CODE_MAX = 3'd4;

  // Byte positions inside the header
  localparam logic [6:0] POS_FLAGS   = 7'd3;
  localparam logic [6:0] POS_SRS_END = 7'd7;

  // Result kinds
  localparam logic [2:0] KIND_SRS     = 3'd0;
  localparam logic [2:0] KIND_SUMMARY = 3'd7;

  // Summary status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_BAD_ENV   = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // Default depth of the result queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // One step's results: an optional value item and an optional summary item
  typedef struct packed {
    logic        has_val;
    logic [2:0]  val_kind;
    logic [63:0] val_value;
    logic        has_sum;
    logic [1:0]  sum_status;
    logic [6:0]  sum_hlen;
    logic [7:0]  flags;
  } gbhp_rec_t;

  // Envelope dimensions for a valid envelope code
  function automatic logic [2:0] dims_of_code(input logic [2:0] code);
    logic [2:0] d;
    unique case (code)
      3'd0:    d = 3'd0;
      3'd1:    d = 3'd2;
      3'd2:    d = 3'd3;
      3'd3:    d = 3'd3;
      3'd4:    d = 3'd4;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

  // Envelope carries Z extents
  function automatic logic code_has_z(input logic [2:0] code);
    return (code == 3'd2) || (code == 3'd4);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gbhp_front.sv
// Front end: accepts blob bytes, tracks the header position and assembles values.
// Pushes one record per byte that yields results into the queue; uses gbhp_pkg.
`default_nettype none

module gbhp_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [7:0]            in_data_byte,
  input  wire                   in_first_byte,
  input  wire                   in_last_byte,
  input  wire                   q_full,
  output logic                  q_wr_en,
  output gbhp_pkg::gbhp_rec_t   q_wr_data
);
  import gbhp_pkg::*;

  logic [6:0]  pos_r, pos_nxt, pos_e;
  logic [7:0]  flags_r, flags_nxt, flags_e;
  logic [2:0]  dims_r, dims_nxt, dims_e;
  logic [63:0] shift_r, shift_nxt, shift_e, shift_base;
  logic        done_r, done_nxt, done_e;
  logic        accept;
  logic        err;
  logic [7:0]  expect_byte;
  logic [2:0]  lane;
  logic [3:0]  dim_idx;
  logic [6:0]  hlen;
  logic [2:0]  code;
  gbhp_rec_t   rec;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Parse one byte
  always_comb begin
    pos_e   = in_first_byte ? 7'd0  : pos_r;
    flags_e = in_first_byte ? 8'd0  : flags_r;
    dims_e  = in_first_byte ? 3'd0  : dims_r;
    shift_e = in_first_byte ? 64'd0 : shift_r;
    done_e  = in_first_byte ? 1'b0  : done_r;

    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    dims_nxt  = dims_r;
    shift_nxt = shift_r;
    done_nxt  = done_r;
    rec       = '0;
    err       = 1'b0;
    hlen      = 7'd0;
    code      = flags_e[3:1];

    unique case (pos_e[1:0])
      2'd0:    expect_byte = MAGIC_0;
      2'd1:    expect_byte = MAGIC_1;
      default: expect_byte = VERSION_BYTE;
    endcase

    // Byte index inside the value being assembled
    lane       = (pos_e < 7'd8) ? {1'b0, pos_e[1:0]} : pos_e[2:0];
    dim_idx    = pos_e[6:3] - 4'd1;
    shift_base = (lane == 3'd0) ? 64'd0 : shift_e;

    if (accept) begin
      pos_nxt   = pos_e;
      flags_nxt = flags_e;
      dims_nxt  = dims_e;
      shift_nxt = shift_e;
      done_nxt  = done_e;
      if (!done_e) begin
        if (pos_e < POS_FLAGS) begin
          // Magic and version check
          if (in_data_byte != expect_byte) begin
            flags_nxt      = 8'd0;
            rec.has_sum    = 1'b1;
            rec.sum_status = ST_BAD_MAGIC;
            done_nxt       = 1'b1;
            err            = 1'b1;
          end
        end else if (pos_e == POS_FLAGS) begin
          // Flags byte
          flags_nxt = in_data_byte;
          if (in_data_byte[3:1] > ENV_CODE_MAX) begin
            rec.has_sum    = 1'b1;
            rec.sum_status = ST_BAD_ENV;
            done_nxt       = 1'b1;
            err            = 1'b1;
          end else begin
            dims_nxt = dims_of_code(in_data_byte[3:1]);
          end
        end else begin
          // Assemble the srs id or an envelope double
          if (flags_e[FLAG_LE_BIT]) begin
            shift_nxt = shift_base;
            for (int i = 0; i < 8; i++) begin
              if (lane == 3'(i)) shift_nxt[8*i +: 8] = in_data_byte;
            end
          end else begin
            shift_nxt = {shift_base[55:0], in_data_byte};
          end
          if (pos_e == POS_SRS_END) begin
            rec.has_val   = 1'b1;
            rec.val_kind  = KIND_SRS;
            rec.val_value = {32'd0, shift_nxt[31:0]};
          end else if (pos_e >= 7'd8 && lane == 3'd7) begin
            if (dim_idx < 4'd4 || (dim_idx < 4'd6 && code_has_z(code))) begin
              rec.has_val   = 1'b1;
              rec.val_kind  = dim_idx[2:0] + 3'd1;
              rec.val_value = shift_nxt;
            end
          end
        end

        // Header completion or early end
        if (!err) begin
          pos_nxt = pos_e + 7'd1;
          hlen    = {dims_nxt, 4'd0} + 7'd8;
          if (pos_e >= POS_SRS_END && pos_nxt == hlen) begin
            rec.has_sum    = 1'b1;
            rec.sum_status = ST_OK;
            rec.sum_hlen   = hlen;
            done_nxt       = 1'b1;
          end else if (in_last_byte) begin
            rec.has_sum    = 1'b1;
            rec.sum_status = ST_TRUNC;
            done_nxt       = 1'b1;
          end
        end
      end
    end
    rec.flags = flags_nxt;
  end

  assign q_wr_en   = accept && (rec.has_val || rec.has_sum);
  assign q_wr_data = rec;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 7'd0;
      flags_r <= 8'd0;
      dims_r  <= 3'd0;
      shift_r <= 64'd0;
      done_r  <= 1'b1;
    end else begin
      pos_r   <= pos_nxt;
      flags_r <= flags_nxt;
      dims_r  <= dims_nxt;
      shift_r <= shift_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gbhp_queue.sv
// Small register queue of result records between front and back.
// One write and one read per cycle; uses gbhp_pkg for the record type.
`default_nettype none

module gbhp_queue #(
  parameter int DEPTH = gbhp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr_en,
  input  gbhp_pkg::gbhp_rec_t  wr_data,
  input  wire                  rd_en,
  output gbhp_pkg::gbhp_rec_t  rd_data,
  output logic                 full,
  output logic                 empty
);
  import gbhp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  gbhp_rec_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd)      count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

FILE: rtl/gbhp_back.sv
// Back end: takes records from the queue and emits their value and summary items.
// Holds one record in an output register; uses gbhp_pkg.
`default_nettype none

module gbhp_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  gbhp_pkg::gbhp_rec_t  q_rd_data,
  output logic                 q_rd_en,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [2:0]           out_field_kind,
  output logic [63:0]          out_field_value,
  output logic [1:0]           out_status,
  output logic                 out_is_empty,
  output logic                 out_is_extended,
  output logic                 out_little_endian,
  output logic                 out_has_xy,
  output logic                 out_has_z,
  output logic [6:0]           out_header_length,
  output logic                 out_last_of_run
);
  import gbhp_pkg::*;

  gbhp_rec_t rec_r, rec_nxt;
  logic      valid_r, valid_nxt;
  logic      sum_phase_r, sum_phase_nxt;
  logic      out_accept;
  logic      rec_done;
  logic [2:0] code;

  assign out_accept = valid_r && !out_stall;
  // Record is finished when its summary goes, or its value goes with no summary
  assign rec_done   = out_accept && (sum_phase_r || !rec_r.has_sum);
  assign q_rd_en    = (!valid_r || rec_done) && !q_empty;

  // Step through the held record and load the next one
  always_comb begin
    rec_nxt       = rec_r;
    valid_nxt     = valid_r;
    sum_phase_nxt = sum_phase_r;
    if (out_accept && !rec_done) begin
      sum_phase_nxt = 1'b1;
    end else if (!valid_r || rec_done) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        rec_nxt       = q_rd_data;
        sum_phase_nxt = !q_rd_data.has_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      sum_phase_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      sum_phase_r <= sum_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  // Drive result fields from the held record
  assign code              = rec_r.flags[3:1];
  assign out_valid         = valid_r;
  assign out_field_kind    = sum_phase_r ? KIND_SUMMARY : rec_r.val_kind;
  assign out_field_value   = sum_phase_r ? 64'd0 : rec_r.val_value;
  assign out_status        = sum_phase_r ? rec_r.sum_status : ST_OK;
  assign out_header_length = sum_phase_r ? rec_r.sum_hlen : 7'd0;
  assign out_last_of_run   = sum_phase_r;
  assign out_is_empty      = rec_r.flags[FLAG_EMPTY_BIT];
  assign out_is_extended   = rec_r.flags[FLAG_EXT_BIT];
  assign out_little_endian = rec_r.flags[FLAG_LE_BIT];
  assign out_has_xy        = (code != 3'd0) && (code <= ENV_CODE_MAX);
  assign out_has_z         = code_has_z(code);

endmodule

`default_nettype wire

FILE: rtl/gpkg_binary_header_parser.sv
// Geometry blob header parser, one byte per item at one item per cycle. A byte
// is taken in the cycle it is offered unless the result queue is full; while
// the queue is full every byte stalls, whether it would produce a result or
// not. A byte that completes a value and also ends the header yields two result
// items, which the output stage sends one after the other, so the sustained
// rate is set by the output side: one result item per cycle while out_stall is
// low. A byte's first result goes through the queue and the output register
// before it can be taken. The queue depth, plus the one record held at the
// output, sets how many result-producing bytes can be absorbed while the
// output is stalled. Uses gbhp_pkg, gbhp_front, gbhp_queue and gbhp_back.
`default_nettype none

module gpkg_binary_header_parser #(
  parameter int QUEUE_DEPTH = gbhp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_first_byte,
  input  wire         in_last_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_field_kind,
  output logic [63:0] out_field_value,
  output logic [1:0]  out_status,
  output logic        out_is_empty,
  output logic        out_is_extended,
  output logic        out_little_endian,
  output logic        out_has_xy,
  output logic        out_has_z,
  output logic [6:0]  out_header_length,
  output logic        out_last_of_run
);
  import gbhp_pkg::*;

  gbhp_rec_t q_wr_data, q_rd_data;
  logic      q_wr_en, q_rd_en, q_full, q_empty;

  // Classify bytes and assemble values
  gbhp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .q_full        (q_full),
    .q_wr_en       (q_wr_en),
    .q_wr_data     (q_wr_data)
  );

  // Buffer result records
  gbhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Emit result items
  gbhp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rd_data         (q_rd_data),
    .q_rd_en           (q_rd_en),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_field_kind    (out_field_kind),
    .out_field_value   (out_field_value),
    .out_status        (out_status),
    .out_is_empty      (out_is_empty),
    .out_is_extended   (out_is_extended),
    .out_little_endian (out_little_endian),
    .out_has_xy        (out_has_xy),
    .out_has_z         (out_has_z),
    .out_header_length (out_header_length),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

`default_nettype wire

FILE: sim/tb_gpkg_binary_header_parser.sv
// Self-checking bench for gpkg_binary_header_parser: directed byte table, then random blobs.
// Results are predicted by a local header parser and checked in order; needs gbhp_pkg and
// the parser RTL only.
`default_nettype none

module tb_gpkg_binary_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import gbhp_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_AFTER   = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 1820;
  localparam int DRAIN_CYCLES = 16;
  localparam int DIR_ROWS     = 25;

  typedef enum logic [2:0] {ENV_NONE, ENV_XY, ENV_XYZ, ENV_XYM, ENV_XYZM} env_code_e;
  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_TYPED} row_mode_e;

  // One result item as the parser presents it
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [1:0]  status;
    logic        empty;
    logic        ext;
    logic        le;
    logic        has_xy;
    logic        has_z;
    logic [6:0]  hlen;
    logic        last;
  } hdr_field_t;

  // Directed row: byte, marks, how it is checked, and the typed summary fields
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    row_mode_e  mode;
    logic [1:0] status;
    logic       empty;
    logic       ext;
    logic       le;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_field_kind;
  logic [63:0] out_field_value;
  logic [1:0]  out_status;
  logic        out_is_empty;
  logic        out_is_extended;
  logic        out_little_endian;
  logic        out_has_xy;
  logic        out_has_z;
  logic [6:0]  out_header_length;
  logic        out_last_of_run;

  // Header parser state mirrored by the predictor
  logic [6:0]  hp_pos   = '0;
  logic [7:0]  hp_flags = '0;
  int          hp_dims  = 0;
  logic [63:0] hp_acc   = '0;
  logic        hp_idle  = 1'b1;

  hdr_field_t fields_due [$];
  hdr_field_t step_fields [$];
  dir_row_t   dir_tbl [DIR_ROWS];

  bit send_burst    = 1'b0;
  int bytes_taken   = 0;
  int parsed_bytes  = 0;
  int blobs_sent    = 0;
  int fields_checked = 0;
  int errors        = 0;
  int status_seen [4] = '{default: 0};

  gpkg_binary_header_parser DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_field_kind    (out_field_kind),
    .out_field_value   (out_field_value),
    .out_status        (out_status),
    .out_is_empty      (out_is_empty),
    .out_is_extended   (out_is_extended),
    .out_little_endian (out_little_endian),
    .out_has_xy        (out_has_xy),
    .out_has_z         (out_has_z),
    .out_header_length (out_header_length),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Envelope dimensions carried by a legal envelope code
  function automatic int env_dims(logic [2:0] code);
    case (code)
      ENV_XY:           return 2;
      ENV_XYZ, ENV_XYM: return 3;
      ENV_XYZM:         return 4;
      default:          return 0;
    endcase
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Append one result item, with flag fields taken from the flags byte held so far
  function automatic void add_field(logic [2:0] kind, logic [63:0] value, logic [1:0] status,
                                    logic [6:0] hlen, logic last);
    hdr_field_t it;
    it.kind   = kind;
    it.value  = value;
    it.status = status;
    it.empty  = hp_flags[FLAG_EMPTY_BIT];
    it.ext    = hp_flags[FLAG_EXT_BIT];
    it.le     = hp_flags[FLAG_LE_BIT];
    it.has_xy = (hp_flags[3:1] >= ENV_XY) && (hp_flags[3:1] <= ENV_XYZM);
    it.has_z  = (hp_flags[3:1] == ENV_XYZ) || (hp_flags[3:1] == ENV_XYZM);
    it.hlen   = hlen;
    it.last   = last;
    step_fields.push_back(it);
  endfunction

  // Advance the header parser by one byte; results land in step_fields
  function automatic void parse_byte(logic [7:0] b, bit f, bit l);
    logic [6:0] pos;
    logic [7:0] want;
    int k, d, hlen;
    step_fields.delete();
    if (f) begin
      hp_pos   = '0;
      hp_flags = '0;
      hp_dims  = 0;
      hp_acc   = '0;
      hp_idle  = 1'b0;
    end
    if (hp_idle) return;
    parsed_bytes++;
    pos = hp_pos;
    if (pos < POS_FLAGS) begin
      // check magic and version
      want = (pos == 7'd0) ? MAGIC_0 : ((pos == 7'd1) ? MAGIC_1 : VERSION_BYTE);
      if (b != want) begin
        hp_flags = '0;
        add_field(KIND_SUMMARY, '0, ST_BAD_MAGIC, '0, 1'b1);
        hp_idle = 1'b1;
        return;
      end
    end else if (pos == POS_FLAGS) begin
      hp_flags = b;
      if (b[3:1] > ENV_CODE_MAX) begin
        add_field(KIND_SUMMARY, '0, ST_BAD_ENV, '0, 1'b1);
        hp_idle = 1'b1;
        return;
      end
      hp_dims = env_dims(b[3:1]);
    end else begin
      // shift the byte into the value under assembly, in header byte order
      k = (pos < 7'd8) ? int'(pos[2:0]) - 4 : int'(pos[2:0]);
      if (k == 0) hp_acc = '0;
      if (hp_flags[FLAG_LE_BIT]) hp_acc = hp_acc | (64'(b) << (8 * k));
      else hp_acc = {hp_acc[55:0], b};
      if (pos == POS_SRS_END) begin
        add_field(KIND_SRS, {32'd0, hp_acc[31:0]}, ST_OK, '0, 1'b0);
      end else if (pos >= 7'd8 && k == 7) begin
        // drop M extents
        d = (int'(pos) - 8) >> 3;
        if (d < 4 || (d < 6 && (hp_flags[3:1] == ENV_XYZ || hp_flags[3:1] == ENV_XYZM)))
          add_field(3'(d + 1), hp_acc, ST_OK, '0, 1'b0);
      end
    end
    hp_pos = pos + 7'd1;
    hlen = 8 + 16 * hp_dims;
    if (pos >= POS_SRS_END && hp_pos == 7'(hlen)) begin
      add_field(KIND_SUMMARY, '0, ST_OK, 7'(hlen), 1'b1);
      hp_idle = 1'b1;
    end else if (l) begin
      add_field(KIND_SUMMARY, '0, ST_TRUNC, '0, 1'b1);
      hp_idle = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_one(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Offer one byte after a random gap and hold it until taken
  task automatic send_byte(logic [7:0] b, bit f, bit l, row_mode_e mode, hdr_field_t typed);
    int gap;
    gap = pick_gap(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_first_byte <= f;
    in_last_byte  <= l;
    do @(posedge clk); while (in_stall);
    bytes_taken++;
    parse_byte(b, f, l);
    if (mode == ROW_TYPED) fields_due.push_back(typed);
    else if (mode == ROW_PREDICT)
      foreach (step_fields[i]) fields_due.push_back(step_fields[i]);
  endtask

  // Build and send one random blob: mostly well-formed headers, plus broken ones and noise
  task automatic send_blob();
    logic [7:0] bytes_q [$];
    logic [7:0] flags;
    int roll, cut, hdr_len, last_at, n, bad_pos;
    bit with_first;
    roll       = $urandom_range(0, 99);
    with_first = 1'b1;
    last_at    = -1;
    send_burst = ($urandom_range(0, 5) == 0);
    bytes_q    = '{MAGIC_0, MAGIC_1, VERSION_BYTE};
    if (roll < 74) begin
      // well-formed header, random content, varied ending
      flags = 8'($urandom);
      flags[3:1] = 3'($urandom_range(0, int'(ENV_CODE_MAX)));
      bytes_q.push_back(flags);
      hdr_len = 8 + 16 * env_dims(flags[3:1]);
      while (bytes_q.size() < hdr_len) bytes_q.push_back(8'($urandom));
      cut = $urandom_range(0, 9);
      if (cut < 2) begin
        last_at = $urandom_range(0, hdr_len - 2);
        bytes_q = bytes_q[0:last_at];
      end else if (cut < 5) begin
        last_at = hdr_len - 1;
      end else if (cut < 9) begin
        n = $urandom_range(1, 6);
        repeat (n) bytes_q.push_back(8'($urandom));
        last_at = bytes_q.size() - 1;
      end else begin
        // stop mid-header; a later blob with a start mark restarts the parser
        n = $urandom_range(1, hdr_len - 2);
        bytes_q = bytes_q[0:n];
      end
    end else if (roll < 84) begin
      // corrupt one magic or version byte
      bad_pos = $urandom_range(0, 2);
      bytes_q[bad_pos] = bytes_q[bad_pos] ^ 8'($urandom_range(1, 255));
      n = $urandom_range(0, 5);
      repeat (n) bytes_q.push_back(8'($urandom));
      if ($urandom_range(0, 1)) last_at = bytes_q.size() - 1;
    end else if (roll < 94) begin
      // illegal envelope code
      flags = 8'($urandom);
      flags[3:1] = 3'($urandom_range(int'(ENV_CODE_MAX) + 1, 7));
      bytes_q.push_back(flags);
      n = $urandom_range(0, 4);
      repeat (n) bytes_q.push_back(8'($urandom));
      if ($urandom_range(0, 1)) last_at = bytes_q.size() - 1;
    end else begin
      // stray bytes with no start mark
      bytes_q.delete();
      with_first = 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) bytes_q.push_back(8'($urandom));
      if ($urandom_range(0, 1)) last_at = $urandom_range(0, n - 1);
    end
    blobs_sent++;
    foreach (bytes_q[i])
      send_byte(bytes_q[i], with_first && i == 0, i == last_at, ROW_PREDICT, '0);
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin : take_result
    hdr_field_t seen, want;
    if (rst_n && out_valid && !out_stall) begin
      seen.kind   = out_field_kind;
      seen.value  = out_field_value;
      seen.status = out_status;
      seen.empty  = out_is_empty;
      seen.ext    = out_is_extended;
      seen.le     = out_little_endian;
      seen.has_xy = out_has_xy;
      seen.has_z  = out_has_z;
      seen.hlen   = out_header_length;
      seen.last   = out_last_of_run;
      if (fields_due.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing expected", seen.kind));
      end else begin
        want = fields_due.pop_front();
        check_one("field_kind", seen.kind, want.kind);
        check_one("field_value", seen.value, want.value);
        check_one("status", seen.status, want.status);
        check_one("is_empty", seen.empty, want.empty);
        check_one("is_extended", seen.ext, want.ext);
        check_one("little_endian", seen.le, want.le);
        check_one("has_xy", seen.has_xy, want.has_xy);
        check_one("has_z", seen.has_z, want.has_z);
        check_one("header_length", seen.hlen, want.hlen);
        check_one("last_of_run", seen.last, want.last);
        if (want.kind == KIND_SUMMARY) status_seen[want.status]++;
        fields_checked++;
      end
    end
  end

  // Result side: random stalls, free-running stretches, one long hold-off
  initial begin : result_sink
    int stall_len, free_len;
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && bytes_taken >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 4);
      out_stall <= 1'b0;
      repeat (free_len) @(negedge clk);
      stall_len = pick_gap(1'b0);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  // End the run when neither channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no item moved for %0d cycles, %0d results pending",
             IDLE_LIMIT, fields_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    hdr_field_t typed;
    int random_start;
    bit paused;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_first_byte = 1'b0;
    in_last_byte  = 1'b0;
    paused        = 1'b0;

    // data, first, last, check, summary status, empty, extended, little-endian
    dir_tbl = '{
      // idle after reset: ignored
      '{MAGIC_0, 1'b0, 1'b0, ROW_QUIET,   ST_OK,        1'b0, 1'b0, 1'b0},
      // bad first magic byte
      '{8'h00,   1'b1, 1'b0, ROW_TYPED,   ST_BAD_MAGIC, 1'b0, 1'b0, 1'b0},
      // bad second magic byte
      '{MAGIC_0, 1'b1, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{8'h51,   1'b0, 1'b0, ROW_TYPED,   ST_BAD_MAGIC, 1'b0, 1'b0, 1'b0},
      // bad version
      '{MAGIC_0, 1'b1, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{MAGIC_1, 1'b0, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{8'h01,   1'b0, 1'b0, ROW_TYPED,   ST_BAD_MAGIC, 1'b0, 1'b0, 1'b0},
      // envelope code 7 with every flag bit set
      '{MAGIC_0, 1'b1, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{MAGIC_1, 1'b0, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{VERSION_BYTE, 1'b0, 1'b0, ROW_PREDICT, ST_OK,   1'b0, 1'b0, 1'b0},
      '{8'hFF,   1'b0, 1'b0, ROW_TYPED,   ST_BAD_ENV,   1'b1, 1'b1, 1'b1},
      // byte after a summary, even with an end mark, is ignored
      '{8'hAA,   1'b0, 1'b1, ROW_QUIET,   ST_OK,        1'b0, 1'b0, 1'b0},
      // minimal little-endian header, end mark on the final header byte
      '{MAGIC_0, 1'b1, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{MAGIC_1, 1'b0, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{VERSION_BYTE, 1'b0, 1'b0, ROW_PREDICT, ST_OK,   1'b0, 1'b0, 1'b0},
      '{8'h01,   1'b0, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{8'hFF,   1'b0, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{8'hFF,   1'b0, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{8'hFF,   1'b0, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{8'hFF,   1'b0, 1'b1, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      // one-byte blob: truncated
      '{MAGIC_0, 1'b1, 1'b1, ROW_TYPED,   ST_TRUNC,     1'b0, 1'b0, 1'b0},
      // envelope code 5 together with an end mark
      '{MAGIC_0, 1'b1, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{MAGIC_1, 1'b0, 1'b0, ROW_PREDICT, ST_OK,        1'b0, 1'b0, 1'b0},
      '{VERSION_BYTE, 1'b0, 1'b0, ROW_PREDICT, ST_OK,   1'b0, 1'b0, 1'b0},
      '{8'h0A,   1'b0, 1'b1, ROW_TYPED,   ST_BAD_ENV,   1'b0, 1'b0, 1'b0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    foreach (dir_tbl[i]) begin
      typed        = '0;
      typed.kind   = KIND_SUMMARY;
      typed.status = dir_tbl[i].status;
      typed.empty  = dir_tbl[i].empty;
      typed.ext    = dir_tbl[i].ext;
      typed.le     = dir_tbl[i].le;
      typed.last   = 1'b1;
      send_byte(dir_tbl[i].data, dir_tbl[i].first, dir_tbl[i].last, dir_tbl[i].mode, typed);
    end

    // random blobs; pause once midway until every result is back
    random_start = bytes_taken;
    while (bytes_taken - random_start < RANDOM_BYTES) begin
      if (!paused && bytes_taken - random_start > RANDOM_BYTES / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (fields_due.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
      send_blob();
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d random blobs plus %0d table rows; %0d parsed, %0d results",
             bytes_taken, blobs_sent, DIR_ROWS, parsed_bytes, fields_checked);
    $display("Headers closed: %0d ok, %0d bad magic/version, %0d bad envelope, %0d truncated",
             status_seen[ST_OK], status_seen[ST_BAD_MAGIC], status_seen[ST_BAD_ENV],
             status_seen[ST_TRUNC]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
